// ----- hw/rtl/sorted_timer_event_queue_assert.svh -----
// Assertion macros used by the back end of the sorted timer event queue RTL.
`ifndef SORTED_TIMER_EVENT_QUEUE_ASSERT_SVH
`define SORTED_TIMER_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define STEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted timer queue: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define STEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted timer queue: next-cycle check failed");

`endif

// ----- hw/rtl/steq_pkg.sv -----
// Shared types and constants of the sorted timer event queue.
`timescale 1ns / 1ps
`default_nettype none

package steq_pkg;

    // Fixed field widths
    localparam int NOW_BITS    = 64;
    localparam int FREQ_BITS   = 32;
    localparam int SECS_BITS   = 16;
    localparam int PROD_BITS   = FREQ_BITS + SECS_BITS;
    localparam int STATUS_BITS = 2;

    // Frequency after reset, and timeout used when the queue runs empty
    localparam logic [FREQ_BITS-1:0] FREQ_RESET   = 32'd62500000;
    localparam logic [SECS_BITS-1:0] IDLE_SECONDS = 16'hFFFF;

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_EXPIRE = 1'b1;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    // Depth of the command queue between front and back
    localparam int FIFO_DEPTH = 2;

    // Classified command: opcode and the absolute time it carries
    // (expiry for an insert, idle compare value for an expire)
    typedef struct packed {
        logic                op;
        logic [NOW_BITS-1:0] value;
    } steq_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/steq_fifo.sv -----
// Small command queue between the front and the back of the timer queue.
`timescale 1ns / 1ps
`default_nettype none

module steq_fifo #(
    parameter int WIDTH = 73,
    parameter int DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [WIDTH-1:0]             push_data,
    input  wire logic                         pop,
    output logic                              not_empty,
    output logic [WIDTH-1:0]                  pop_data,
    output logic [$clog2(DEPTH+1)-1:0]        fill
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             do_push, do_pop;

    assign do_push   = push && (fill_reg != CW'(DEPTH));
    assign do_pop    = pop && (fill_reg != '0);
    assign not_empty = (fill_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign fill      = fill_reg;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/steq_front.sv -----
// Front end: takes words, holds the frequency, computes the absolute time.
`timescale 1ns / 1ps
`default_nettype none

module steq_front #(
    parameter int TAG_BITS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [steq_pkg::FREQ_BITS-1:0] cfg_data,
    input  wire logic                           accept,
    input  wire logic                           opcode,
    input  wire logic [steq_pkg::NOW_BITS-1:0]  now_count,
    input  wire logic [steq_pkg::SECS_BITS-1:0] delay_seconds,
    input  wire logic [TAG_BITS-1:0]            event_tag,
    output logic                                push_valid,
    output steq_pkg::steq_cmd_t                 push_cmd,
    output logic [TAG_BITS-1:0]                 push_tag
);

    logic [steq_pkg::FREQ_BITS-1:0] freq_reg, freq_next;
    logic                           valid_reg, valid_next;
    logic                           op_reg, op_next;
    logic [steq_pkg::NOW_BITS-1:0]  now_reg, now_next;
    logic [steq_pkg::PROD_BITS-1:0] prod_reg, prod_next;
    logic [TAG_BITS-1:0]            tag_reg, tag_next;
    logic [steq_pkg::SECS_BITS-1:0] secs_sel;

    // An expire carries the idle timeout so the back gets its fallback compare
    assign secs_sel = (opcode == steq_pkg::OP_EXPIRE) ? steq_pkg::IDLE_SECONDS : delay_seconds;

    // Stage 1: scale the timeout
    always_comb
    begin
        freq_next  = cfg_write ? cfg_data : freq_reg;
        valid_next = accept;
        op_next    = accept ? opcode : op_reg;
        now_next   = accept ? now_count : now_reg;
        tag_next   = accept ? event_tag : tag_reg;
        prod_next  = accept ? (steq_pkg::PROD_BITS'(freq_reg) *
                               steq_pkg::PROD_BITS'(secs_sel)) : prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg  <= steq_pkg::FREQ_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            freq_reg  <= freq_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        now_reg  <= now_next;
        prod_reg <= prod_next;
        tag_reg  <= tag_next;
    end

    // Stage 2: absolute time, wraps modulo 2^64, straight into the queue
    assign push_valid     = valid_reg;
    assign push_cmd.op    = op_reg;
    assign push_cmd.value = now_reg + steq_pkg::NOW_BITS'(prod_reg);
    assign push_tag       = tag_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/steq_back.sv -----
// Back end: chain of sorted cells, compare register and result word.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_timer_event_queue_assert.svh"

module steq_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire steq_pkg::steq_cmd_t               in_cmd,
    input  wire logic [TAG_BITS-1:0]               in_tag,
    output logic                                   done,
    output logic                                   fired,
    output logic [TAG_BITS-1:0]                    fired_tag,
    output logic [steq_pkg::NOW_BITS-1:0]          compare_value,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       entry_count,
    output logic [steq_pkg::STATUS_BITS-1:0]       status
);

    localparam int CW = $clog2(QUEUE_DEPTH+1);

    logic [steq_pkg::NOW_BITS-1:0]    exp_reg [QUEUE_DEPTH];
    logic [steq_pkg::NOW_BITS-1:0]    exp_next [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]              tag_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]              tag_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]           ins_here;

    logic [CW-1:0]                    count_reg, count_next;
    logic [steq_pkg::NOW_BITS-1:0]    compare_reg, compare_next;
    logic                             done_reg, done_next;
    logic                             fired_reg, fired_next;
    logic [TAG_BITS-1:0]              ftag_reg, ftag_next;
    logic [steq_pkg::STATUS_BITS-1:0] status_reg, status_next;

    logic full, empty, is_insert, is_expire, do_ins, do_pop;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign is_insert = in_valid && (in_cmd.op == steq_pkg::OP_INSERT);
    assign is_expire = in_valid && (in_cmd.op == steq_pkg::OP_EXPIRE);
    assign do_ins    = is_insert && !full;
    assign do_pop    = is_expire && !empty;

    // Sorted cells: each compares its own entry, shifts right on insert,
    // left on pop. Entries past the count hold don't-care data.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic shift_in;
        logic [steq_pkg::NOW_BITS-1:0] left_exp, right_exp;
        logic [TAG_BITS-1:0]           left_tag, right_tag;

        // new word goes before the first valid entry strictly later than it
        assign ins_here[i] = (CW'(i) < count_reg) ? (exp_reg[i] > in_cmd.value) : 1'b1;

        if (i == 0)
        begin : g_head
            assign shift_in = 1'b0;
            assign left_exp = exp_reg[i];
            assign left_tag = tag_reg[i];
        end
        else
        begin : g_body
            assign shift_in = ins_here[i-1];
            assign left_exp = exp_reg[i-1];
            assign left_tag = tag_reg[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_exp = exp_reg[i];
            assign right_tag = tag_reg[i];
        end
        else
        begin : g_inner
            assign right_exp = exp_reg[i+1];
            assign right_tag = tag_reg[i+1];
        end

        always_comb
        begin
            exp_next[i] = exp_reg[i];
            tag_next[i] = tag_reg[i];
            if (do_ins)
            begin
                if (shift_in)
                begin
                    exp_next[i] = left_exp;
                    tag_next[i] = left_tag;
                end
                else if (ins_here[i])
                begin
                    exp_next[i] = in_cmd.value;
                    tag_next[i] = in_tag;
                end
            end
            else if (do_pop)
            begin
                exp_next[i] = right_exp;
                tag_next[i] = right_tag;
            end
        end

        always_ff @(posedge clk)
        begin
            exp_reg[i] <= exp_next[i];
            tag_reg[i] <= tag_next[i];
        end
    end

    // Count, compare value and result word
    always_comb
    begin
        count_next   = count_reg;
        compare_next = compare_reg;
        done_next    = in_valid;
        fired_next   = 1'b0;
        ftag_next    = '0;
        status_next  = steq_pkg::ST_OK;
        if (is_insert)
        begin
            if (full)
            begin
                status_next = steq_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
                if (ins_here[0])
                begin
                    compare_next = in_cmd.value;
                end
            end
        end
        else if (is_expire)
        begin
            if (empty)
            begin
                status_next  = steq_pkg::ST_EMPTY;
                compare_next = in_cmd.value;
            end
            else
            begin
                fired_next   = 1'b1;
                ftag_next    = tag_reg[0];
                count_next   = count_reg - CW'(1);
                compare_next = (count_reg == CW'(1)) ? in_cmd.value : exp_reg[1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            compare_reg <= '1;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            compare_reg <= compare_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fired_reg  <= fired_next;
        ftag_reg   <= ftag_next;
        status_reg <= status_next;
    end

    assign done          = done_reg;
    assign fired         = fired_reg;
    assign fired_tag     = ftag_reg;
    assign compare_value = compare_reg;
    assign entry_count   = count_reg;
    assign status        = status_reg;

    // Checks
    `STEQ_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `STEQ_ASSERT_SAME(a_head_sorted, clk, rst_n, count_reg >= CW'(2), exp_reg[0] <= exp_reg[1])
    `STEQ_ASSERT_SAME(a_fired_ok, clk, rst_n, done_reg && fired_reg, status_reg == steq_pkg::ST_OK)
    `STEQ_ASSERT_NEXT(a_pop_dec, clk, rst_n, do_pop, count_reg == $past(count_reg) - CW'(1))
    `STEQ_ASSERT_NEXT(a_full_hold, clk, rst_n, is_insert && full, count_reg == $past(count_reg))

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_timer_event_queue.sv -----
// Top level of the sorted timer event queue.
//
//   channel   direction  handshake                     payload
//   command   in         start high, busy low          opcode now_count delay_seconds event_tag
//   result    out        done high for one cycle       fired fired_tag compare_value
//                                                      entry_count status
//   config    in         cfg_write high                cfg_data (counter_frequency)
//
// A word accepted at the input passes the multiply stage, then the command queue after
// the add, then the cell chain update that loads the result registers on the ports.
// busy rises when the command queue and the multiply stage together hold FIFO_DEPTH
// words, so a new word can be taken while earlier ones are still in flight.
// Reset clears the queue count, sets the compare value to all ones and the
// frequency to 62500000. The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_event_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [steq_pkg::FREQ_BITS-1:0]    cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              opcode,
    input  wire logic [steq_pkg::NOW_BITS-1:0]     now_count,
    input  wire logic [steq_pkg::SECS_BITS-1:0]    delay_seconds,
    input  wire logic [TAG_BITS-1:0]               event_tag,
    output logic                                   done,
    output logic                                   fired,
    output logic [TAG_BITS-1:0]                    fired_tag,
    output logic [steq_pkg::NOW_BITS-1:0]          compare_value,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       entry_count,
    output logic [steq_pkg::STATUS_BITS-1:0]       status
);

    localparam int FW = $bits(steq_pkg::steq_cmd_t) + TAG_BITS;
    localparam int QW = $clog2(steq_pkg::FIFO_DEPTH+1);

    logic                      accept;
    logic                      push_valid;
    steq_pkg::steq_cmd_t       push_cmd;
    logic [TAG_BITS-1:0]       push_tag;
    logic                      q_valid;
    logic [FW-1:0]             q_data;
    steq_pkg::steq_cmd_t       q_cmd;
    logic [TAG_BITS-1:0]       q_tag;
    logic [QW-1:0]             q_fill;

    // Credit check: queued words plus the one in the multiply stage
    assign busy   = (QW'(q_fill) + QW'(push_valid)) >= QW'(steq_pkg::FIFO_DEPTH);
    assign accept = start && !busy;

    steq_front #(
        .TAG_BITS (TAG_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .opcode        (opcode),
        .now_count     (now_count),
        .delay_seconds (delay_seconds),
        .event_tag     (event_tag),
        .push_valid    (push_valid),
        .push_cmd      (push_cmd),
        .push_tag      (push_tag)
    );

    steq_fifo #(
        .WIDTH (FW),
        .DEPTH (steq_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data ({push_cmd, push_tag}),
        .pop       (q_valid),
        .not_empty (q_valid),
        .pop_data  (q_data),
        .fill      (q_fill)
    );

    assign q_cmd = q_data[FW-1:TAG_BITS];
    assign q_tag = q_data[TAG_BITS-1:0];

    steq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (q_valid),
        .in_cmd        (q_cmd),
        .in_tag        (q_tag),
        .done          (done),
        .fired         (fired),
        .fired_tag     (fired_tag),
        .compare_value (compare_value),
        .entry_count   (entry_count),
        .status        (status)
    );

endmodule

`default_nettype wire

// ----- tb/sorted_timer_event_queue_tb.sv -----
// Self-checking testbench for the sorted timer event queue.
`timescale 1ns / 1ps

module sorted_timer_event_queue_tb;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TAG_BITS     = 8;
    localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 7;
    localparam int PIPE_LATENCY = 3;
    localparam int PHASE_WORDS  = 100;

    // One result word as seen on the output ports
    typedef struct packed {
        logic                             fired;
        logic [TAG_BITS-1:0]              tag;
        logic [steq_pkg::NOW_BITS-1:0]    compare;
        logic [CNT_BITS-1:0]              count;
        logic [steq_pkg::STATUS_BITS-1:0] status;
    } timer_word_t;

    // Sorted event list mirror and the queue of result words still owed
    class timer_queue_scoreboard;
        logic [steq_pkg::NOW_BITS-1:0]  expiry_list[$];
        logic [TAG_BITS-1:0]            tag_list[$];
        logic [steq_pkg::NOW_BITS-1:0]  compare_reg;
        logic [steq_pkg::FREQ_BITS-1:0] ticks_per_sec;
        timer_word_t                    owed_words[$];
        int                             errors;

        function new();
            compare_reg   = '1;
            ticks_per_sec = steq_pkg::FREQ_RESET;
            errors        = 0;
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        function logic [steq_pkg::NOW_BITS-1:0] deadline(
            logic [steq_pkg::NOW_BITS-1:0] now,
            logic [steq_pkg::SECS_BITS-1:0] secs);
            return now + 64'(ticks_per_sec) * 64'(secs);
        endfunction

        // Apply one accepted command word and queue the word it must produce
        function void note_command(logic op, logic [steq_pkg::NOW_BITS-1:0] now,
                                   logic [steq_pkg::SECS_BITS-1:0] secs,
                                   logic [TAG_BITS-1:0] tag);
            timer_word_t                   w;
            logic [steq_pkg::NOW_BITS-1:0] expiry_at;
            int                            pos;
            w = '0;
            w.status = steq_pkg::ST_OK;
            if (op == steq_pkg::OP_INSERT)
            begin
                if (expiry_list.size() >= QUEUE_DEPTH)
                begin
                    w.status = steq_pkg::ST_FULL;
                end
                else
                begin
                    expiry_at = deadline(now, secs);
                    // stable: goes after every equal expiry
                    pos = 0;
                    while (pos < expiry_list.size() && expiry_list[pos] <= expiry_at)
                        pos++;
                    expiry_list.insert(pos, expiry_at);
                    tag_list.insert(pos, tag);
                    if (pos == 0)
                        compare_reg = expiry_at;
                end
            end
            else if (expiry_list.size() == 0)
            begin
                w.status    = steq_pkg::ST_EMPTY;
                compare_reg = deadline(now, steq_pkg::IDLE_SECONDS);
            end
            else
            begin
                w.fired = 1'b1;
                w.tag   = tag_list.pop_front();
                void'(expiry_list.pop_front());
                if (expiry_list.size() == 0)
                    compare_reg = deadline(now, steq_pkg::IDLE_SECONDS);
                else
                    compare_reg = expiry_list[0];
            end
            w.compare = compare_reg;
            w.count   = CNT_BITS'(expiry_list.size());
            owed_words.push_back(w);
        endfunction

        function void check_field(string name, logic [steq_pkg::NOW_BITS-1:0] want,
                                  logic [steq_pkg::NOW_BITS-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one result word with the oldest one owed
        function void check_result(timer_word_t got);
            timer_word_t want;
            if (owed_words.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = owed_words.pop_front();
            check_field("fired", 64'(want.fired), 64'(got.fired));
            check_field("fired_tag", 64'(want.tag), 64'(got.tag));
            check_field("compare_value", want.compare, got.compare);
            check_field("entry_count", 64'(want.count), 64'(got.count));
            check_field("status", 64'(want.status), 64'(got.status));
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [steq_pkg::FREQ_BITS-1:0]   cfg_data;
    logic                             start;
    logic                             busy;
    logic                             opcode;
    logic [steq_pkg::NOW_BITS-1:0]    now_count;
    logic [steq_pkg::SECS_BITS-1:0]   delay_seconds;
    logic [TAG_BITS-1:0]              event_tag;
    logic                             done;
    logic                             fired;
    logic [TAG_BITS-1:0]              fired_tag;
    logic [steq_pkg::NOW_BITS-1:0]    compare_value;
    logic [CNT_BITS-1:0]              entry_count;
    logic [steq_pkg::STATUS_BITS-1:0] status;

    timer_queue_scoreboard         sb;
    logic [steq_pkg::NOW_BITS-1:0] wall_clock;

    sorted_timer_event_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .now_count     (now_count),
        .delay_seconds (delay_seconds),
        .event_tag     (event_tag),
        .done          (done),
        .fired         (fired),
        .fired_tag     (fired_tag),
        .compare_value (compare_value),
        .entry_count   (entry_count),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Accepted command words feed the prediction
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_command(opcode, now_count, delay_seconds, event_tag);
    end

    // Every done strobe is one result word
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({fired, fired_tag, compare_value, entry_count, status});
    end

    // Present one command word and hold it until accepted
    task automatic drive_word(logic op, logic [steq_pkg::NOW_BITS-1:0] now,
                              logic [steq_pkg::SECS_BITS-1:0] secs,
                              logic [TAG_BITS-1:0] tag);
        @(negedge clk);
        start         <= 1'b1;
        opcode        <= op;
        now_count     <= now;
        delay_seconds <= secs;
        event_tag     <= tag;
        do @(posedge clk); while (busy);
    endtask

    // Sender gap; the payload carries noise meanwhile
    task automatic pause_sender(int cycles);
        if (cycles == 0)
            return;
        @(negedge clk);
        start         <= 1'b0;
        opcode        <= 1'($urandom);
        now_count     <= {$urandom, $urandom};
        delay_seconds <= 16'($urandom);
        event_tag     <= 8'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Stop sending until every owed word has come back
    task automatic drain_queue();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    task automatic write_frequency(logic [steq_pkg::FREQ_BITS-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.ticks_per_sec = value;
    endtask

    function automatic logic [steq_pkg::NOW_BITS-1:0] pick_now();
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return '1 - 64'($urandom_range(0, 1000));
            default:
            begin
                wall_clock = wall_clock + 64'($urandom_range(0, 3000));
                return wall_clock;
            end
        endcase
    endfunction

    function automatic logic [steq_pkg::SECS_BITS-1:0] pick_seconds();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 7));
        endcase
    endfunction

    // Fill the queue past full, check ordering, wrap and the empty expire
    task automatic run_directed();
        drive_word(steq_pkg::OP_EXPIRE, '1, '0, '0);
        drive_word(steq_pkg::OP_INSERT, '0, '0, 8'h00);
        drive_word(steq_pkg::OP_INSERT, '1, '1, 8'hFF);
        // equal expiries must leave in arrival order
        for (int k = 1; k <= 3; k++)
            drive_word(steq_pkg::OP_INSERT, 64'd100, 16'd5, 8'(k));
        for (int k = 6; k < QUEUE_DEPTH + 1; k++)
            drive_word(steq_pkg::OP_INSERT, 64'(k) * 64'd1000,
                       16'($urandom_range(0, 10)), 8'(k));
        // queue full: both dropped, even one that would tie the current head
        drive_word(steq_pkg::OP_INSERT, '0, '0, 8'hA5);
        drive_word(steq_pkg::OP_INSERT, 64'd12345, 16'd3, 8'h5A);
        repeat (4) drive_word(steq_pkg::OP_EXPIRE, 64'd200, 16'($urandom), 8'($urandom));
    endtask

    // Bursts of random words; insert share varies to swing between empty and full
    task automatic run_random(int words);
        int sent;
        int burst;
        int insert_pct;
        sent = 0;
        while (sent < words)
        begin
            burst = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
                0: insert_pct = 15;
                1: insert_pct = 50;
                default: insert_pct = 85;
            endcase
            repeat (burst)
            begin
                drive_word(($urandom_range(0, 99) < insert_pct) ?
                               steq_pkg::OP_INSERT : steq_pkg::OP_EXPIRE,
                           pick_now(), pick_seconds(), 8'($urandom));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        sb            = new();
        wall_clock    = '0;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_data      = '0;
        start         = 1'b0;
        opcode        = steq_pkg::OP_INSERT;
        now_count     = '0;
        delay_seconds = '0;
        event_tag     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(PHASE_WORDS / 2);

        // frequency settings: extremes, zero, reset value and a random one
        drain_queue();
        write_frequency(32'd1);
        run_random(PHASE_WORDS);
        drain_queue();
        write_frequency('1);
        run_random(PHASE_WORDS);
        drain_queue();
        write_frequency('0);
        run_random(PHASE_WORDS / 2);
        drain_queue();
        write_frequency($urandom);
        run_random(PHASE_WORDS);
        drain_queue();
        write_frequency(steq_pkg::FREQ_RESET);
        run_random(PHASE_WORDS / 2);

        drain_queue();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("sorted_timer_event_queue_tb: PASS");
        else
            $display("sorted_timer_event_queue_tb: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("sorted_timer_event_queue_tb: FAIL");
        $finish;
    end

endmodule
